// ===== design/qrbv_pkg.sv =====
// Shared types and codes for the queue with remove-by-value.
package qrbv_pkg;

  // Action codes carried by an input word
  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP_HEAD = 2'd1,
    ACT_POP_TAIL = 2'd2,
    ACT_REMOVE   = 2'd3
  } action_t;

  // Status codes carried by a result word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Memory operation requested of the datapath in one cycle
  typedef enum logic [2:0] {
    DP_NONE    = 3'd0,
    DP_PUSH    = 3'd1,
    DP_RD_HEAD = 3'd2,
    DP_RD_TAIL = 3'd3,
    DP_SCAN    = 3'd4,
    DP_SHIFT   = 3'd5
  } dp_op_t;

  // Source of the removed value in a result word
  typedef enum logic [1:0] {
    REM_ZERO  = 2'd0,
    REM_RDATA = 2'd1,
    REM_VALUE = 2'd2
  } rem_src_t;

  // Change of the entry count
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    dp_op_t   op;
    logic     load;
    logic     mark;
    logic     head_inc;
    cnt_op_t  cnt_op;
    logic     fin;
    status_t  fin_status;
    rem_src_t rem_src;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic scan_last;
    logic shift_last;
  } dp_stat_t;

endpackage

// ===== design/qrbv_dp.sv =====
// Datapath: circular entry store, head and count registers, scan and compaction pointers.
module qrbv_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qrbv_pkg::dp_cmd_t  cmd,
  input  logic signed [31:0] in_item_value,
  output qrbv_pkg::dp_stat_t stat,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [4:0]         out_entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Map a position counted from the head onto a store address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lidx);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(lidx);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;
  logic signed [31:0] value_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      wr_idx_r;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] wr_data;
  logic signed [31:0] rem_val;
  logic [CW+4:0]      cnt_ext;

  // Status toward the controller
  assign stat.full       = (count_r == CW'(DEPTH));
  assign stat.empty      = (count_r == '0);
  assign stat.match      = (rd_data_r == value_r);
  assign stat.scan_last  = (idx_r == count_r);
  assign stat.shift_last = ((SW'(wr_idx_r) + SW'(1)) >= SW'(count_r));

  // Select store read and write for the requested operation
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r;
    wr_en   = 1'b0;
    wr_addr = phys(head_r, count_r);
    wr_data = in_item_value;
    unique case (cmd.op)
      qrbv_pkg::DP_PUSH: begin
        wr_en = 1'b1;
      end
      qrbv_pkg::DP_RD_HEAD: begin
        rd_en = 1'b1;
      end
      qrbv_pkg::DP_RD_TAIL: begin
        rd_en   = 1'b1;
        rd_addr = phys(head_r, count_r - CW'(1));
      end
      qrbv_pkg::DP_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = phys(head_r, idx_r);
      end
      qrbv_pkg::DP_SHIFT: begin
        rd_en   = 1'b1;
        rd_addr = phys(head_r, wr_idx_r + CW'(2));
        wr_en   = 1'b1;
        wr_addr = phys(head_r, wr_idx_r);
        wr_data = rd_data_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Store with registered read data
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Next head and count
  always_comb begin
    head_nxt = head_r;
    if (cmd.head_inc) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
    unique case (cmd.cnt_op)
      qrbv_pkg::CNT_INC: count_nxt = count_r + CW'(1);
      qrbv_pkg::CNT_DEC: count_nxt = count_r - CW'(1);
      default:           count_nxt = count_r;
    endcase
  end

  // Hold head and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Latch the search value and advance the scan and compaction pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_item_value;
      idx_r   <= '0;
    end else if (cmd.op == qrbv_pkg::DP_SCAN) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.mark) begin
      wr_idx_r <= idx_r - CW'(1);
    end else if (cmd.op == qrbv_pkg::DP_SHIFT) begin
      wr_idx_r <= wr_idx_r + CW'(1);
    end
  end

  // Result word fields
  always_comb begin
    unique case (cmd.rem_src)
      qrbv_pkg::REM_RDATA: rem_val = rd_data_r;
      qrbv_pkg::REM_VALUE: rem_val = value_r;
      default:             rem_val = '0;
    endcase
  end

  assign cnt_ext = (CW + 5)'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_status        <= cmd.fin_status;
      out_removed_value <= rem_val;
      out_entry_count   <= cnt_ext[4:0];
    end
  end

endmodule

// ===== design/qrbv_ctrl.sv =====
// Controller: sequences push, pops and the scan-and-compact removal.
module qrbv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_action,
  input  qrbv_pkg::dp_stat_t stat,
  output logic               busy,
  output logic               out_strobe,
  output qrbv_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_H,
    S_POP_T,
    S_SCAN0,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t              state_r, state_nxt;
  logic                strobe_r;
  logic                accept;
  qrbv_pkg::action_t   act;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign act        = qrbv_pkg::action_t'(in_action);
  assign out_strobe = strobe_r;

  // Decode state and status into datapath commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (act == qrbv_pkg::ACT_PUSH) begin
            cmd.fin = 1'b1;
            if (stat.full) begin
              cmd.fin_status = qrbv_pkg::ST_FULL;
            end else begin
              cmd.op         = qrbv_pkg::DP_PUSH;
              cmd.cnt_op     = qrbv_pkg::CNT_INC;
              cmd.fin_status = qrbv_pkg::ST_OK;
            end
          end else if (stat.empty) begin
            cmd.fin        = 1'b1;
            cmd.fin_status = qrbv_pkg::ST_EMPTY;
          end else begin
            unique case (act)
              qrbv_pkg::ACT_POP_HEAD: begin
                cmd.op    = qrbv_pkg::DP_RD_HEAD;
                state_nxt = S_POP_H;
              end
              qrbv_pkg::ACT_POP_TAIL: begin
                cmd.op    = qrbv_pkg::DP_RD_TAIL;
                state_nxt = S_POP_T;
              end
              default: begin
                cmd.load  = 1'b1;
                state_nxt = S_SCAN0;
              end
            endcase
          end
        end
      end
      S_POP_H: begin
        cmd.fin        = 1'b1;
        cmd.fin_status = qrbv_pkg::ST_OK;
        cmd.rem_src    = qrbv_pkg::REM_RDATA;
        cmd.cnt_op     = qrbv_pkg::CNT_DEC;
        cmd.head_inc   = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_POP_T: begin
        cmd.fin        = 1'b1;
        cmd.fin_status = qrbv_pkg::ST_OK;
        cmd.rem_src    = qrbv_pkg::REM_RDATA;
        cmd.cnt_op     = qrbv_pkg::CNT_DEC;
        state_nxt      = S_IDLE;
      end
      S_SCAN0: begin
        cmd.op    = qrbv_pkg::DP_SCAN;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // Compare the word read last cycle while reading the next one
        if (stat.match) begin
          cmd.mark = 1'b1;
          if (!stat.scan_last) cmd.op = qrbv_pkg::DP_SCAN;
          state_nxt = S_SHIFT;
        end else if (stat.scan_last) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = qrbv_pkg::ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op = qrbv_pkg::DP_SCAN;
        end
      end
      S_SHIFT: begin
        // Move each later entry one place toward the head
        if (stat.shift_last) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = qrbv_pkg::ST_OK;
          cmd.rem_src    = qrbv_pkg::REM_VALUE;
          cmd.cnt_op     = qrbv_pkg::CNT_DEC;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op = qrbv_pkg::DP_SHIFT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= cmd.fin;
    end
  end

endmodule

// ===== design/queue_with_remove_by_value_core.sv =====
// Push: result strobe in the cycle after accept; pop head or tail: the entry is read, then
// S_POP_H or S_POP_T finishes the word. Remove by value: the scan reads the store one entry a
// cycle up to a match or the last entry; on a match, compaction reads and writes it one entry a cycle.
// One word at a time: busy is high until the last cycle of the word, and the next
// word is accepted in the cycle its result strobe shows; the receiver cannot stall.
// Synchronous active-low reset empties the queue; store contents are not cleared.
module queue_with_remove_by_value_core #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_item_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [4:0]         out_entry_count
);

  qrbv_pkg::dp_cmd_t  cmd;
  qrbv_pkg::dp_stat_t stat;

  // Sequence each word
  qrbv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_action  (in_action),
    .stat       (stat),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // Store, pointers and result fields
  qrbv_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_item_value     (in_item_value),
    .stat              (stat),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

endmodule
